[rtl/wwhc_pkg.sv]
`default_nettype none
package wwhc_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ADDR_W  = SLOT_W + 1;
    localparam int CNT_W   = ADDR_W + 1;

    localparam logic [1:0] CMD_DELTA = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEGATIVE = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_ACC_CAP = 2'd1;
    localparam logic [1:0] REG_STO_CAP = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DRD,
        S_DCHK,
        S_SCAN,
        S_QSET,
        S_WRD,
        S_WCHK,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

[rtl/windowed_weight_histogram_cutoff.sv]
`default_nettype none
// Two windowed weight histograms (account, storage) kept in one 2*SLOTS-entry ring
// memory, one beat in and one beat out per item, one item in flight at a time.
// After reset a clearing pass walks the ring once before s_tready rises. The ring
// has a single read port, and a sweep reads one entry per cycle. A delta reads its
// slot, checks it and, without conflict or underflow, writes it back; a close sweeps
// the whole ring unless current_block <= window_len; a query, per kind, sweeps that
// kind's SLOTS entries for the oldest bucket, sets up, then walks at most window_len
// blocks downward, before the single output beat.
module windowed_weight_histogram_cutoff (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // bucket_block[63:0], delta[127:64], current_block[191:128]
    input  wire logic [191:0] s_tdata,
    // cmd[1:0], kind[2]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // account_cutoff[63:0], storage_cutoff[127:64], status[129:128], zero pad
    output logic [135:0]      m_tdata
);

    localparam int NTOT = 2 * wwhc_pkg::SLOTS;

    logic        mem_valid  [NTOT];
    logic [63:0] mem_tag    [NTOT];
    logic [63:0] mem_weight [NTOT];

    logic [wwhc_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic        wr_en, wr_valid;
    logic [63:0] wr_tag, wr_weight;
    logic        rd_valid_reg;
    logic [63:0] rd_tag_reg, rd_weight_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_valid[wr_addr]  <= wr_valid;
            mem_tag[wr_addr]    <= wr_tag;
            mem_weight[wr_addr] <= wr_weight;
        end
        rd_valid_reg  <= mem_valid[rd_addr];
        rd_tag_reg    <= mem_tag[rd_addr];
        rd_weight_reg <= mem_weight[rd_addr];
    end

    wwhc_pkg::state_t state_reg, state_next;
    logic [7:0]  wl_reg;
    logic [63:0] acap_reg, scap_reg;
    logic [1:0]  cmd_reg, cmd_next;
    logic        kind_reg, kind_next;
    logic [63:0] bkt_reg, bkt_next, dlt_reg, dlt_next, blk_reg, blk_next;
    logic [wwhc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [wwhc_pkg::ADDR_W-1:0] paddr_reg, paddr_next;
    logic        any_reg, any_next;
    logic [63:0] old_reg, old_next, floor_reg, floor_next, cur_reg, cur_next;
    logic [63:0] sum_reg, sum_next, acc_reg, acc_next;
    logic [1:0]  stat_reg, stat_next;
    logic        mv_reg, mv_next;
    logic [135:0] md_reg, md_next;

    logic [63:0] wfl, cap, w, mag, nw, res, fl, nsum;
    logic [64:0] sum65;
    logic        kdone, is_close;
    logic [wwhc_pkg::CNT_W-1:0] lim;

    assign s_tready = (state_reg == wwhc_pkg::S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    assign wfl = (blk_reg > {56'd0, wl_reg}) ? blk_reg - {56'd0, wl_reg} : 64'd0;
    assign cap = kind_reg ? scap_reg : acap_reg;
    assign is_close = (cmd_reg == wwhc_pkg::CMD_CLOSE);
    assign lim = is_close ? wwhc_pkg::CNT_W'(NTOT) : wwhc_pkg::CNT_W'(wwhc_pkg::SLOTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wwhc_pkg::S_CLEAR;
            wl_reg    <= 8'd255;
            acap_reg  <= 64'd0;
            scap_reg  <= 64'd0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    wwhc_pkg::REG_WINDOW:  wl_reg   <= cfg_wr_data[7:0];
                    wwhc_pkg::REG_ACC_CAP: acap_reg <= cfg_wr_data;
                    wwhc_pkg::REG_STO_CAP: scap_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        kind_reg  <= kind_next;
        bkt_reg   <= bkt_next;
        dlt_reg   <= dlt_next;
        blk_reg   <= blk_next;
        paddr_reg <= paddr_next;
        any_reg   <= any_next;
        old_reg   <= old_next;
        floor_reg <= floor_next;
        cur_reg   <= cur_next;
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        stat_reg  <= stat_next;
        md_reg    <= md_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;   kind_next = kind_reg;
        bkt_next = bkt_reg;   dlt_next = dlt_reg;   blk_next = blk_reg;
        cnt_next = cnt_reg;   pend_next = 1'b0;     paddr_next = paddr_reg;
        any_next = any_reg;   old_next = old_reg;   floor_next = floor_reg;
        cur_next = cur_reg;   sum_next = sum_reg;   acc_next = acc_reg;
        stat_next = stat_reg; md_next = md_reg;
        mv_next = mv_reg & ~m_tready;
        rd_addr = cnt_reg[wwhc_pkg::ADDR_W-1:0];
        wr_en = 1'b0; wr_addr = paddr_reg; wr_valid = 1'b0;
        wr_tag = bkt_reg; wr_weight = 64'd0;
        w = rd_valid_reg ? rd_weight_reg : 64'd0;
        mag = ~dlt_reg + 64'd1;
        nw = 64'd0;
        sum65 = {1'b0, sum_reg} + {1'b0, rd_weight_reg};
        nsum = sum65[64] ? {64{1'b1}} : sum65[63:0];
        fl = (wfl > old_reg) ? wfl : old_reg;
        res = 64'd0;
        kdone = 1'b0;

        case (state_reg)
            wwhc_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = cnt_reg[wwhc_pkg::ADDR_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wwhc_pkg::CNT_W'(NTOT - 1)) begin
                    cnt_next = '0;
                    state_next = wwhc_pkg::S_IDLE;
                end
            end
            wwhc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = s_tuser[1:0];
                    kind_next = s_tuser[2];
                    bkt_next = s_tdata[63:0];
                    dlt_next = s_tdata[127:64];
                    blk_next = s_tdata[191:128];
                    stat_next = wwhc_pkg::ST_OK;
                    acc_next = 64'd0;
                    cnt_next = '0;
                    any_next = 1'b0;
                    case (s_tuser[1:0])
                        wwhc_pkg::CMD_DELTA:
                            state_next = (s_tdata[63:0] == 64'd0 || s_tdata[127:64] == 64'd0)
                                ? wwhc_pkg::S_OUT : wwhc_pkg::S_DRD;
                        wwhc_pkg::CMD_CLOSE: begin
                            state_next = wwhc_pkg::S_SCAN;
                            kind_next = 1'b1;
                        end
                        wwhc_pkg::CMD_QUERY: begin
                            state_next = wwhc_pkg::S_SCAN;
                            kind_next = 1'b0;
                        end
                        default: state_next = wwhc_pkg::S_OUT;
                    endcase
                end
            end
            wwhc_pkg::S_DRD: begin
                rd_addr = {kind_reg, bkt_reg[wwhc_pkg::SLOT_W-1:0]};
                paddr_next = rd_addr;
                state_next = wwhc_pkg::S_DCHK;
            end
            wwhc_pkg::S_DCHK: begin
                state_next = wwhc_pkg::S_OUT;
                if (rd_valid_reg && rd_tag_reg != bkt_reg) begin
                    stat_next = wwhc_pkg::ST_CONFLICT;
                end else if (dlt_reg[63] && mag > w) begin
                    stat_next = wwhc_pkg::ST_NEGATIVE;
                end else begin
                    if (dlt_reg[63]) begin
                        nw = w - mag;
                    end else begin
                        sum65 = {1'b0, w} + {1'b0, dlt_reg};
                        nw = sum65[64] ? {64{1'b1}} : sum65[63:0];
                    end
                    wr_en = 1'b1;
                    wr_valid = (nw != 64'd0);
                    wr_weight = nw;
                end
            end
            wwhc_pkg::S_SCAN: begin
                // pipelined sweep: issue entry cnt, inspect the entry read last cycle
                if (is_close && blk_reg <= {56'd0, wl_reg}) begin
                    state_next = wwhc_pkg::S_OUT;
                end else begin
                    rd_addr = is_close ? cnt_reg[wwhc_pkg::ADDR_W-1:0]
                                       : {kind_reg, cnt_reg[wwhc_pkg::SLOT_W-1:0]};
                    if (cnt_reg < lim) begin
                        pend_next = 1'b1;
                        paddr_next = rd_addr;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (pend_reg && rd_valid_reg) begin
                        if (is_close) begin
                            if (rd_tag_reg < wfl) begin
                                wr_en = 1'b1;
                                wr_tag = rd_tag_reg;
                            end
                        end else if (!any_reg || rd_tag_reg < old_reg) begin
                            any_next = 1'b1;
                            old_next = rd_tag_reg;
                        end
                    end
                    if (!(cnt_reg < lim) && !pend_reg)
                        state_next = is_close ? wwhc_pkg::S_OUT : wwhc_pkg::S_QSET;
                end
            end
            wwhc_pkg::S_QSET: begin
                sum_next = 64'd0;
                floor_next = fl;
                cur_next = blk_reg - 64'd1;
                if (!any_reg) begin
                    kdone = 1'b1;
                    res = (blk_reg == 64'd0) ? 64'd0 : blk_reg - 64'd1;
                end else if (blk_reg == 64'd0) begin
                    kdone = 1'b1;
                    res = fl - 64'd1;
                end else begin
                    state_next = wwhc_pkg::S_WRD;
                end
            end
            wwhc_pkg::S_WRD: begin
                // floor is never 0 here since live tags are nonzero
                if (cur_reg < floor_reg) begin
                    kdone = 1'b1;
                    res = floor_reg - 64'd1;
                end else begin
                    rd_addr = {kind_reg, cur_reg[wwhc_pkg::SLOT_W-1:0]};
                    state_next = wwhc_pkg::S_WCHK;
                end
            end
            wwhc_pkg::S_WCHK: begin
                state_next = wwhc_pkg::S_WRD;
                cur_next = cur_reg - 64'd1;
                if (rd_valid_reg && rd_tag_reg == cur_reg) begin
                    sum_next = nsum;
                    if (nsum > cap) begin
                        kdone = 1'b1;
                        res = cur_reg;
                    end
                end
            end
            wwhc_pkg::S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    md_next = {6'd0, stat_reg,
                               (cmd_reg == wwhc_pkg::CMD_QUERY) ? cur_reg : 64'd0, acc_reg};
                    state_next = wwhc_pkg::S_IDLE;
                end
            end
            default: state_next = wwhc_pkg::S_IDLE;
        endcase

        // one kind's walk finished: account goes on to storage, storage to output
        if (kdone) begin
            if (!kind_reg) begin
                acc_next = res;
                kind_next = 1'b1;
                cnt_next = '0;
                any_next = 1'b0;
                state_next = wwhc_pkg::S_SCAN;
            end else begin
                cur_next = res;
                state_next = wwhc_pkg::S_OUT;
            end
        end
    end

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT   = 8000000;
    localparam int DRAIN   = 1600;   // idle cycles after the last awaited result
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  cmd;
        logic        kind;
        logic [63:0] bucket;
        logic [63:0] delta;
        logic [63:0] cur;
    } hist_item_t;

    typedef struct {
        logic [63:0] acc;
        logic [63:0] sto;
        logic [1:0]  status;
    } cutoff_t;

    class cutoff_scoreboard;
        bit          live[2*wwhc_pkg::SLOTS];
        logic [63:0] tag[2*wwhc_pkg::SLOTS];
        logic [63:0] weight[2*wwhc_pkg::SLOTS];
        logic [63:0] window_len = 255;
        logic [63:0] acc_cap = 0;
        logic [63:0] sto_cap = 0;
        cutoff_t     awaited[$];
        int          errors = 0;

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                wwhc_pkg::REG_WINDOW:  window_len = {56'd0, val[7:0]};
                wwhc_pkg::REG_ACC_CAP: acc_cap = val;
                wwhc_pkg::REG_STO_CAP: sto_cap = val;
                default: ;
            endcase
        endfunction

        function logic [1:0] apply_delta(logic kind, logic [63:0] bkt, logic [63:0] dlt);
            int          idx;
            logic [63:0] w;
            logic [63:0] mag;
            logic [64:0] s;
            logic [63:0] nw;
            if (bkt == 0 || dlt == 0) return wwhc_pkg::ST_OK;
            idx = (kind ? wwhc_pkg::SLOTS : 0) + int'(bkt % wwhc_pkg::SLOTS);
            if (live[idx] && tag[idx] != bkt) return wwhc_pkg::ST_CONFLICT;
            w = live[idx] ? weight[idx] : 64'd0;
            if (dlt[63]) begin
                mag = -dlt;
                if (mag > w) return wwhc_pkg::ST_NEGATIVE;
                nw = w - mag;
            end else begin
                s = {1'b0, w} + {1'b0, dlt};
                nw = s[64] ? ALL_ONES : s[63:0];
            end
            if (nw == 0) begin
                live[idx] = 0;
            end else begin
                live[idx] = 1;
                tag[idx] = bkt;
                weight[idx] = nw;
            end
            return wwhc_pkg::ST_OK;
        endfunction

        function void prune(logic [63:0] blk);
            logic [63:0] fl;
            if (blk <= window_len) return;
            fl = blk - window_len;
            for (int i = 0; i < 2*wwhc_pkg::SLOTS; i++)
                if (live[i] && tag[i] < fl) live[i] = 0;
        endfunction

        function logic [63:0] cutoff(int base, logic [63:0] blk, logic [63:0] cap);
            bit          any;
            bit          found;
            int          best;
            logic [63:0] oldest;
            logic [63:0] fl;
            logic [63:0] bound;
            logic [64:0] s;
            logic [63:0] sum;
            any = 0;
            oldest = 0;
            for (int i = base; i < base + wwhc_pkg::SLOTS; i++)
                if (live[i] && (!any || tag[i] < oldest)) begin
                    oldest = tag[i];
                    any = 1;
                end
            if (!any) return blk == 0 ? 64'd0 : blk - 1;
            fl = blk > window_len ? blk - window_len : 64'd0;
            if (oldest > fl) fl = oldest;
            bound = blk;
            sum = 0;
            while (1) begin
                found = 0;
                best = 0;
                for (int i = base; i < base + wwhc_pkg::SLOTS; i++)
                    if (live[i] && tag[i] < bound && (!found || tag[i] > tag[best])) begin
                        best = i;
                        found = 1;
                    end
                if (!found || tag[best] < fl) break;
                s = {1'b0, sum} + {1'b0, weight[best]};
                sum = s[64] ? ALL_ONES : s[63:0];
                if (sum > cap) return tag[best];
                bound = tag[best];
            end
            return fl == 0 ? 64'd0 : fl - 1;
        endfunction

        function void note_input(hist_item_t it);
            cutoff_t e;
            e.acc = 0;
            e.sto = 0;
            e.status = wwhc_pkg::ST_OK;
            case (it.cmd)
                wwhc_pkg::CMD_DELTA: e.status = apply_delta(it.kind, it.bucket, it.delta);
                wwhc_pkg::CMD_CLOSE: prune(it.cur);
                wwhc_pkg::CMD_QUERY: begin
                    e.acc = cutoff(0, it.cur, acc_cap);
                    e.sto = cutoff(wwhc_pkg::SLOTS, it.cur, sto_cap);
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        task check_result(logic [135:0] d);
            cutoff_t e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result beat %h", d));
                return;
            end
            e = awaited.pop_front();
            if (d[63:0] !== e.acc)
                report($sformatf("account_cutoff %h, want %h", d[63:0], e.acc));
            if (d[127:64] !== e.sto)
                report($sformatf("storage_cutoff %h, want %h", d[127:64], e.sto));
            if (d[129:128] !== e.status)
                report($sformatf("status %0d, want %0d", d[129:128], e.status));
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_index = 0;
    logic [63:0]  cfg_wr_data = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = 0;
    logic [2:0]   s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;

    cutoff_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    logic [63:0] cb = 100;

    windowed_weight_histogram_cutoff DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** windowed_weight_histogram_cutoff: FAILED **");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a falling edge, returns at a falling edge
    task send(hist_item_t it);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {it.cur, it.delta, it.bucket};
        s_tuser <= {it.kind, it.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    task write_reg(logic [1:0] idx, logic [63:0] val);
        s_tvalid <= 0;
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 0;
        @(negedge aclk);
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    function automatic hist_item_t mk(logic [1:0] c, logic k, logic [63:0] b,
                                      logic [63:0] d, logic [63:0] cur);
        hist_item_t it;
        it.cmd = c;
        it.kind = k;
        it.bucket = b;
        it.delta = d;
        it.cur = cur;
        return it;
    endfunction

    function automatic hist_item_t random_item();
        hist_item_t it;
        int r;
        int q;
        r = $urandom_range(0, 99);
        it = mk(wwhc_pkg::CMD_DELTA, 1'($urandom_range(0, 1)), rand64(), rand64(), rand64());
        if (r < 55) begin
            it.cur = cb;
            it.bucket = cb - 64'($urandom_range(1, 260));
            q = $urandom_range(0, 99);
            if (q < 10) it.bucket = it.bucket + 64'd256;
            q = $urandom_range(0, 99);
            if (q < 85) it.delta = 64'($urandom_range(1, 5000));
            else if (q < 97) it.delta = -64'($urandom_range(1, 5000));
        end else if (r < 65) begin
            it = mk(wwhc_pkg::CMD_CLOSE, 1'($urandom_range(0, 1)), rand64(), rand64(), cb);
        end else if (r < 85) begin
            it = mk(wwhc_pkg::CMD_QUERY, 1'($urandom_range(0, 1)), rand64(), rand64(), cb);
        end else begin
            it.cmd = 2'($urandom_range(0, 3));
        end
        return it;
    endfunction

    initial begin
        hist_item_t dq[$];
        logic [63:0] acc_v, sto_v, win_v;
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: empty queries, ignored deltas, saturation, conflict,
        // negative weight, freeing at zero, pruning, unused command
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 0, 0, 0, 0));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 1, 0, 0, 5));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 0, 77, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 1, 12, 0, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 10, 100, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 1, 10, 64'h7FFF_FFFF_FFFF_FFFF, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 1, 10, 64'h7FFF_FFFF_FFFF_FFFF, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 1, 10, 64'h7FFF_FFFF_FFFF_FFFF, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 266, 5, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 10, -64'd200, 0));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 0, 0, 0, 11));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 10, -64'd100, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, ALL_ONES, 64'h8000_0000_0000_0000, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 1, ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 0));
        dq.push_back(mk(2'd3, 1, ALL_ONES, ALL_ONES, ALL_ONES));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 1, 0, 0, ALL_ONES));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 5, 7, 0));
        dq.push_back(mk(wwhc_pkg::CMD_DELTA, 0, 250, 3, 0));
        dq.push_back(mk(wwhc_pkg::CMD_CLOSE, 0, 0, 0, 3));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 0, 0, 0, 251));
        dq.push_back(mk(wwhc_pkg::CMD_CLOSE, 0, 0, 0, 300));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 0, 0, 0, 300));
        dq.push_back(mk(wwhc_pkg::CMD_CLOSE, 1, 0, 0, ALL_ONES));
        dq.push_back(mk(wwhc_pkg::CMD_QUERY, 0, 0, 0, 1));
        foreach (dq[i]) send(dq[i]);

        for (int p = 0; p < 6; p++) begin
            drain();
            send_idle = (p < 2) ? 31 : (p < 4) ? 87 : 0;
            recv_idle = (p < 2) ? 87 : (p < 4) ? 31 : 0;
            acc_v = 64'($urandom_range(0, 60000));
            sto_v = 64'($urandom_range(0, 60000));
            win_v = 64'($urandom_range(2, 254));
            case (p)
                0: win_v = 255;
                1: begin win_v = 1; acc_v = 0; sto_v = ALL_ONES; end
                2: begin acc_v = ALL_ONES; sto_v = 0; end
                4: win_v = 255;
                default: ;
            endcase
            write_reg(wwhc_pkg::REG_WINDOW, win_v);
            write_reg(wwhc_pkg::REG_ACC_CAP, acc_v);
            write_reg(wwhc_pkg::REG_STO_CAP, sto_v);
            for (int n = 0; n < 115; n++) begin
                if ($urandom_range(0, 99) < 4) begin
                    case ($urandom_range(0, 2))
                        0: cb = rand64();
                        1: cb = ALL_ONES - 64'($urandom_range(0, 300));
                        default: cb = 64'($urandom_range(1, 3000));
                    endcase
                end else if ($urandom_range(0, 99) < 15) begin
                    cb = cb + 64'($urandom_range(0, 40));
                end
                send(random_item());
            end
        end

        s_tvalid <= 0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.errors == 0)
            $display("** windowed_weight_histogram_cutoff: PASSED **");
        else
            $display("** windowed_weight_histogram_cutoff: FAILED **");
        $finish;
    end
endmodule
